// ===== design/icg_pkg.sv =====
// ----------------------------------------------------------------------------
// icg_pkg
// Shared definitions for the idle C-state governor: field widths, timer masks,
// idle level codes, configuration register indexes, reset values and pass_t.
// ----------------------------------------------------------------------------
package icg_pkg;

    // Field widths
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned LEVEL_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Stream payload widths (packed fields rounded up to whole bytes)
    localparam int unsigned IN_FIELDS_W  = 2 + 2 * TICK_W;
    localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned OUT_FIELDS_W = LEVEL_W + 4 + 4 * TICK_W;
    localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Power timer
    localparam int unsigned         TMR_NARROW_BITS = 24;
    localparam logic [TICK_W-1:0]   TMR_MASK_24     = 32'h00FF_FFFF;
    localparam logic [TICK_W-1:0]   TMR_MASK_32     = 32'hFFFF_FFFF;

    // Idle level codes
    localparam logic [LEVEL_W-1:0] LVL_C1 = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_C2 = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_C3 = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_WIDE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C2_EXIT_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C2_ENTER_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C3_EXIT_TICKS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C3_ENTER_TICKS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ARBITER_PRESENT = 3'd6;

    // Configuration reset values
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = LVL_C1;
    localparam logic [TICK_W-1:0]  TICKS_RST     = TMR_MASK_32;

    // One idle pass as held in the input register
    typedef struct packed {
        logic              resched_pending;
        logic              bm_active;
        logic [TICK_W-1:0] start_time;
        logic [TICK_W-1:0] end_time;
    } pass_t;

endpackage

// ===== design/idle_cstate_governor_unit.sv =====
// Path: an accepted input transaction passes through the input register, then
// the result register, to the master side.
// Throughput: one transaction per cycle while the master side takes results; the
// level and entry counters are updated in the single pass between the two registers.
// Reset (aresetn low, synchronous): level returns to C1, counters clear,
// configuration registers take their reset values, both stages empty.
// ----------------------------------------------------------------------------
// idle_cstate_governor_unit
// Idle-depth governor: measures residency per idle pass, promotes or demotes
// the idle level, counts entries per level and flags bus-master handling.
// ----------------------------------------------------------------------------
module idle_cstate_governor_unit
    import icg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // Idle pass input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] resched_pending, [1] bm_active, [33:2] start_time, [65:34] end_time
    input  logic [IN_DATA_W-1:0]  s_tdata,

    // Governor result
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] next_level, [2] exit_idle, [3] clear_bm_status, [4] bm_wakes,
    // [5] park_arbiter, [37:6] residency, [69:38] c1_total,
    // [101:70] c2_total, [133:102] c3_total
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // Configuration registers
    logic              timer_wide_reg;
    logic [LEVEL_W-1:0] max_level_reg;
    logic [TICK_W-1:0] c2_exit_ticks_reg;
    logic [TICK_W-1:0] c2_enter_ticks_reg;
    logic [TICK_W-1:0] c3_exit_ticks_reg;
    logic [TICK_W-1:0] c3_enter_ticks_reg;
    logic              arbiter_present_reg;

    // Governor state
    logic [LEVEL_W-1:0] level_reg,      level_next;
    logic [TICK_W-1:0]  c1_entries_reg, c1_entries_next;
    logic [TICK_W-1:0]  c2_entries_reg, c2_entries_next;
    logic [TICK_W-1:0]  c3_entries_reg, c3_entries_next;

    // Pipeline
    logic                    in_valid_reg;
    pass_t                   in_pass_reg;
    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                    advance;

    // Pass evaluation
    logic [LEVEL_W-1:0] eff_level;
    logic [TICK_W-1:0]  tick_mask;
    logic [TICK_W-1:0]  ticks_diff;
    logic [TICK_W-1:0]  residency;
    logic               exit_idle;
    logic               clear_bm;
    logic               park;
    logic               bm_wakes;

    // Handshake: stage 1 moves on when the result register is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_wide_reg      <= 1'b0;
            max_level_reg       <= MAX_LEVEL_RST;
            c2_exit_ticks_reg   <= TICKS_RST;
            c2_enter_ticks_reg  <= TICKS_RST;
            c3_exit_ticks_reg   <= TICKS_RST;
            c3_enter_ticks_reg  <= TICKS_RST;
            arbiter_present_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TIMER_WIDE:      timer_wide_reg      <= cfg_wdata[0];
                REG_MAX_LEVEL:       max_level_reg       <= cfg_wdata[LEVEL_W-1:0];
                REG_C2_EXIT_TICKS:   c2_exit_ticks_reg   <= cfg_wdata[TICK_W-1:0];
                REG_C2_ENTER_TICKS:  c2_enter_ticks_reg  <= cfg_wdata[TICK_W-1:0];
                REG_C3_EXIT_TICKS:   c3_exit_ticks_reg   <= cfg_wdata[TICK_W-1:0];
                REG_C3_ENTER_TICKS:  c3_enter_ticks_reg  <= cfg_wdata[TICK_W-1:0];
                REG_ARBITER_PRESENT: arbiter_present_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Capture the input transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_pass_reg.resched_pending <= s_tdata[0];
            in_pass_reg.bm_active       <= s_tdata[1];
            in_pass_reg.start_time      <= s_tdata[TICK_W+1:2];
            in_pass_reg.end_time        <= s_tdata[2*TICK_W+1:TICK_W+2];
        end
    end

    // Clamp the stored level by the deepest allowed level
    always_comb begin
        if (level_reg <= LVL_C1 || max_level_reg < LVL_C2) begin
            eff_level = LVL_C1;
        end else if (level_reg == LVL_C2 || max_level_reg < LVL_C3) begin
            eff_level = LVL_C2;
        end else begin
            eff_level = LVL_C3;
        end
    end

    // Residency with wrap at the timer width
    assign tick_mask  = timer_wide_reg ? TMR_MASK_32 : TMR_MASK_24;
    assign ticks_diff = (in_pass_reg.end_time - in_pass_reg.start_time) & tick_mask;
    assign bm_wakes   = (eff_level != LVL_C1);

    // Promote, demote and count
    always_comb begin
        level_next      = eff_level;
        c1_entries_next = c1_entries_reg;
        c2_entries_next = c2_entries_reg;
        c3_entries_next = c3_entries_reg;
        exit_idle       = 1'b0;
        clear_bm        = 1'b0;
        park            = 1'b0;
        residency       = '0;
        if (in_pass_reg.resched_pending) begin
            exit_idle = 1'b1;
        end else if (eff_level == LVL_C1) begin
            c1_entries_next = c1_entries_reg + 1'b1;
            residency       = ticks_diff;
            if (ticks_diff > c2_enter_ticks_reg && max_level_reg >= LVL_C2) begin
                level_next = LVL_C2;
            end
        end else if (eff_level == LVL_C2) begin
            c2_entries_next = c2_entries_reg + 1'b1;
            residency       = ticks_diff;
            if (ticks_diff < c2_exit_ticks_reg) begin
                level_next = LVL_C1;
            end else if (in_pass_reg.bm_active) begin
                clear_bm = 1'b1;
            end else if (ticks_diff > c3_enter_ticks_reg && max_level_reg >= LVL_C3) begin
                level_next = LVL_C3;
            end
        end else if (in_pass_reg.bm_active) begin
            // bus-master activity: skip the C3 sleep
            level_next = LVL_C2;
        end else begin
            c3_entries_next = c3_entries_reg + 1'b1;
            park            = arbiter_present_reg;
            residency       = ticks_diff;
            if (ticks_diff < c3_exit_ticks_reg) begin
                level_next = LVL_C1;
            end
        end
    end

    // Pack the result transaction
    always_comb begin
        out_data_next = '0;
        out_data_next[LEVEL_W-1:0]        = level_next;
        out_data_next[2]                  = exit_idle;
        out_data_next[3]                  = clear_bm;
        out_data_next[4]                  = bm_wakes;
        out_data_next[5]                  = park;
        out_data_next[TICK_W+5:6]         = residency;
        out_data_next[2*TICK_W+5:TICK_W+6]   = c1_entries_next;
        out_data_next[3*TICK_W+5:2*TICK_W+6] = c2_entries_next;
        out_data_next[4*TICK_W+5:3*TICK_W+6] = c3_entries_next;
    end

    // Update state as each pass moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg      <= LVL_C1;
            c1_entries_reg <= '0;
            c2_entries_reg <= '0;
            c3_entries_reg <= '0;
        end else if (advance) begin
            level_reg      <= level_next;
            c1_entries_reg <= c1_entries_next;
            c2_entries_reg <= c2_entries_next;
            c3_entries_reg <= c3_entries_next;
        end
    end

    // Hold the result until the master side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== verif/idle_cstate_governor_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_cstate_governor_unit_test
// Self-checking bench for the idle C-state governor. A short table of idle
// passes and register writes comes first. It is followed by randomised
// phases with fresh settings each time. Every result is compared field by
// field with a typed-in result or with an in-bench governor model. Both
// stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module idle_cstate_governor_unit_test;
    import icg_pkg::*;

    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_PASSES  = 104;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned MAX_REPORTS   = 10;

    // One governor result as carried on m_tdata (last member in the lowest bits)
    typedef struct packed {
        logic [TICK_W-1:0]  c3_total;
        logic [TICK_W-1:0]  c2_total;
        logic [TICK_W-1:0]  c1_total;
        logic [TICK_W-1:0]  residency;
        logic               park_arbiter;
        logic               bm_wakes;
        logic               clear_bm_status;
        logic               exit_idle;
        logic [LEVEL_W-1:0] next_level;
    } gov_result_t;

    typedef enum logic {ROW_CFG, ROW_PASS} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  val;
        logic                   resched;
        logic                   bm;
        logic [TICK_W-1:0]      t0;
        logic [TICK_W-1:0]      t1;
        bit                     typed;
        gov_result_t            want;
    } script_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Shadow copy of the configuration registers
    logic                  wide_timer_sh;
    logic [LEVEL_W-1:0]    max_level_sh;
    logic [TICK_W-1:0]     c2_exit_sh;
    logic [TICK_W-1:0]     c2_enter_sh;
    logic [TICK_W-1:0]     c3_exit_sh;
    logic [TICK_W-1:0]     c3_enter_sh;
    logic                  arbiter_sh;

    // Shadow copy of the governor state
    logic [LEVEL_W-1:0]    level_sh;
    logic [TICK_W-1:0]     c1_count_sh;
    logic [TICK_W-1:0]     c2_count_sh;
    logic [TICK_W-1:0]     c3_count_sh;

    gov_result_t           pending_results[$];
    script_row_t           directed_rows[$];
    gov_result_t           seen_result;
    gov_result_t           oldest_result;
    int unsigned           mismatches = 0;
    int unsigned           cycle_count = 0;
    int unsigned           ready_stall = 0;
    bit                    idling_on = 1'b1;

    idle_cstate_governor_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Work out the result of one idle pass and advance the shadow state
    task automatic govern_pass(input logic resched, input logic bm,
                               input logic [TICK_W-1:0] t0, input logic [TICK_W-1:0] t1,
                               output gov_result_t r);
        logic [LEVEL_W-1:0] eff;
        logic [TICK_W-1:0]  mask;
        logic [TICK_W-1:0]  slept;
        mask  = wide_timer_sh ? TMR_MASK_32 : TMR_MASK_24;
        slept = ((t1 & mask) - (t0 & mask)) & mask;
        if (level_sh <= LVL_C1 || max_level_sh < LVL_C2) begin
            eff = LVL_C1;
        end else if (level_sh == LVL_C2 || max_level_sh < LVL_C3) begin
            eff = LVL_C2;
        end else begin
            eff = LVL_C3;
        end
        r = '0;
        r.next_level = eff;
        r.bm_wakes   = (eff != LVL_C1);
        if (resched) begin
            r.exit_idle = 1'b1;
        end else if (eff == LVL_C1) begin
            c1_count_sh = c1_count_sh + 1;
            r.residency = slept;
            if (slept > c2_enter_sh && max_level_sh >= LVL_C2) r.next_level = LVL_C2;
        end else if (eff == LVL_C2) begin
            c2_count_sh = c2_count_sh + 1;
            r.residency = slept;
            if (slept < c2_exit_sh) begin
                r.next_level = LVL_C1;
            end else if (bm) begin
                r.clear_bm_status = 1'b1;
            end else if (slept > c3_enter_sh && max_level_sh >= LVL_C3) begin
                r.next_level = LVL_C3;
            end
        end else if (bm) begin
            // bus-master activity: skip the C3 sleep and fall back to C2
            r.next_level = LVL_C2;
        end else begin
            c3_count_sh    = c3_count_sh + 1;
            r.park_arbiter = arbiter_sh;
            r.residency    = slept;
            if (slept < c3_exit_sh) r.next_level = LVL_C1;
        end
        level_sh   = r.next_level;
        r.c1_total = c1_count_sh;
        r.c2_total = c2_count_sh;
        r.c3_total = c3_count_sh;
    endtask

    // Write one register at the next edge; the caller lowers the enable
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_TIMER_WIDE:      wide_timer_sh = val[0];
            REG_MAX_LEVEL:       max_level_sh  = val[LEVEL_W-1:0];
            REG_C2_EXIT_TICKS:   c2_exit_sh    = val;
            REG_C2_ENTER_TICKS:  c2_enter_sh   = val;
            REG_C3_EXIT_TICKS:   c3_exit_sh    = val;
            REG_C3_ENTER_TICKS:  c3_enter_sh   = val;
            REG_ARBITER_PRESENT: arbiter_sh    = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Hold the sender until every outstanding result has been received
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Offer one idle pass and record its expected result on acceptance
    task automatic send_pass(input logic resched, input logic bm,
                             input logic [TICK_W-1:0] t0, input logic [TICK_W-1:0] t1,
                             input bit typed, input gov_result_t want);
        gov_result_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, t1, t0, bm, resched};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        govern_pass(resched, bm, t0, t1, r);
        pending_results.push_back(typed ? want : r);
    endtask

    // Occasionally drop valid for a short burst
    task automatic sender_gap();
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        script_row_t row;
        row       = '{kind: ROW_CFG, default: '0};
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.val   = val;
        directed_rows.push_back(row);
    endtask

    task automatic pass_row(input logic resched, input logic bm,
                            input logic [TICK_W-1:0] t0, input logic [TICK_W-1:0] t1);
        script_row_t row;
        row         = '{kind: ROW_PASS, default: '0};
        row.kind    = ROW_PASS;
        row.resched = resched;
        row.bm      = bm;
        row.t0      = t0;
        row.t1      = t1;
        directed_rows.push_back(row);
    endtask

    // C1-only pass with its result typed in; the other fields stay zero
    task automatic typed_row(input logic resched, input logic bm,
                             input logic [TICK_W-1:0] t0, input logic [TICK_W-1:0] t1,
                             input logic ex, input logic [TICK_W-1:0] res,
                             input logic [TICK_W-1:0] c1);
        script_row_t row;
        row                 = '{kind: ROW_PASS, default: '0};
        row.kind            = ROW_PASS;
        row.resched         = resched;
        row.bm              = bm;
        row.t0              = t0;
        row.t1              = t1;
        row.typed           = 1'b1;
        row.want            = '0;
        row.want.next_level = LVL_C1;
        row.want.exit_idle  = ex;
        row.want.residency  = res;
        row.want.c1_total   = c1;
        directed_rows.push_back(row);
    endtask

    function automatic logic [TICK_W-1:0] pick_ticks();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return TMR_MASK_32;
            2:       return $urandom;
            default: return $urandom_range(0, 4000);
        endcase
    endfunction

    // Random pass, with the sleep length biased towards the thresholds
    task automatic random_pass();
        logic [TICK_W-1:0] t0;
        logic [TICK_W-1:0] delta;
        logic [TICK_W-1:0] edge_ticks;
        gov_result_t       unused;
        case ($urandom_range(0, 3))
            0:       edge_ticks = c2_exit_sh;
            1:       edge_ticks = c2_enter_sh;
            2:       edge_ticks = c3_exit_sh;
            default: edge_ticks = c3_enter_sh;
        endcase
        case ($urandom_range(0, 7))
            0:       delta = $urandom;
            1:       delta = '0;
            2, 3:    delta = edge_ticks + $urandom_range(0, 2) - 1;
            default: delta = $urandom_range(0, 5000);
        endcase
        t0     = $urandom;
        unused = '0;
        send_pass($urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0,
                  t0, t0 + delta, 1'b0, unused);
    endtask

    // Receive and check results; stall ready in short random bursts
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_result = m_tdata[OUT_FIELDS_W-1:0];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result transaction: %h", seen_result);
            end else begin
                oldest_result = pending_results.pop_front();
                if (seen_result !== oldest_result) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch lvl/ex/clr/wk/pk exp %0d/%b/%b/%b/%b got %0d/%b/%b/%b/%b",
                                 oldest_result.next_level, oldest_result.exit_idle,
                                 oldest_result.clear_bm_status, oldest_result.bm_wakes,
                                 oldest_result.park_arbiter, seen_result.next_level,
                                 seen_result.exit_idle, seen_result.clear_bm_status,
                                 seen_result.bm_wakes, seen_result.park_arbiter);
                        $display("  res/c1/c2/c3 exp %h/%h/%h/%h got %h/%h/%h/%h",
                                 oldest_result.residency, oldest_result.c1_total,
                                 oldest_result.c2_total, oldest_result.c3_total,
                                 seen_result.residency, seen_result.c1_total,
                                 seen_result.c2_total, seen_result.c3_total);
                    end
                end
            end
        end
        if (ready_stall != 0) begin
            ready_stall--;
            m_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            ready_stall = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int unsigned i;

        // Reset values of the shadow registers and state
        wide_timer_sh = 1'b0;
        max_level_sh  = MAX_LEVEL_RST;
        c2_exit_sh    = TICKS_RST;
        c2_enter_sh   = TICKS_RST;
        c3_exit_sh    = TICKS_RST;
        c3_enter_sh   = TICKS_RST;
        arbiter_sh    = 1'b0;
        level_sh      = LVL_C1;
        c1_count_sh   = '0;
        c2_count_sh   = '0;
        c3_count_sh   = '0;

        // After reset: C1 only, 24-bit timer, thresholds all ones
        typed_row(1'b1, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'd0);
        typed_row(1'b0, 1'b1, 32'hAB00_0010, 32'h1200_0005, 1'b0, 32'h00FF_FFF5, 32'd1);
        typed_row(1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 32'd2);
        typed_row(1'b0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h00FF_FFFF, 32'd3);
        cfg_row(REG_TIMER_WIDE, 32'd1);
        typed_row(1'b0, 1'b0, 32'h0000_0001, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 32'd4);
        typed_row(1'b0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'd5);

        // Walk all three levels with small thresholds
        cfg_row(REG_MAX_LEVEL, LVL_C3);
        cfg_row(REG_C2_ENTER_TICKS, 32'd100);
        cfg_row(REG_C2_EXIT_TICKS, 32'd50);
        cfg_row(REG_C3_ENTER_TICKS, 32'd200);
        cfg_row(REG_C3_EXIT_TICKS, 32'd40);
        cfg_row(REG_ARBITER_PRESENT, 32'd1);
        pass_row(1'b0, 1'b0, 32'd1000, 32'd1100);   // equal to enter: stay in C1
        pass_row(1'b0, 1'b0, 32'd1000, 32'd1101);   // promote to C2
        pass_row(1'b1, 1'b0, 32'd0, 32'd999);       // leave idle in C2
        pass_row(1'b0, 1'b1, 32'd0, 32'd300);       // bus master in C2: clear status
        pass_row(1'b0, 1'b0, 32'd0, 32'd50);        // equal to exit: hold C2
        pass_row(1'b0, 1'b0, 32'd0, 32'd201);       // promote to C3
        pass_row(1'b0, 1'b1, 32'd0, 32'd900);       // bus master in C3: back to C2
        pass_row(1'b0, 1'b0, 32'd0, 32'd300);       // promote to C3
        pass_row(1'b0, 1'b0, 32'd10, 32'd50);       // C3 equal to exit: stay, park
        pass_row(1'b1, 1'b1, 32'd0, 32'd1);         // leave idle in C3
        pass_row(1'b0, 1'b0, 32'd0, 32'd39);        // short C3 sleep: demote to C1
        pass_row(1'b0, 1'b0, 32'd5, 32'd4);         // wrapped timer: promote to C2
        pass_row(1'b0, 1'b0, 32'd0, 32'd49);        // short C2 sleep: demote to C1
        pass_row(1'b0, 1'b0, 32'd0, 32'd500);
        pass_row(1'b0, 1'b0, 32'd0, 32'd500);

        // Stored C3 clamped by a lower maximum
        cfg_row(REG_MAX_LEVEL, LVL_C2);
        cfg_row(REG_ARBITER_PRESENT, 32'd0);
        pass_row(1'b0, 1'b0, 32'd0, 32'd500);
        cfg_row(REG_MAX_LEVEL, LVL_C1);
        pass_row(1'b0, 1'b0, 32'd0, 32'd500);

        // Zero thresholds, 24-bit timer
        cfg_row(REG_TIMER_WIDE, 32'd0);
        cfg_row(REG_MAX_LEVEL, LVL_C3);
        cfg_row(REG_C2_EXIT_TICKS, 32'd0);
        cfg_row(REG_C2_ENTER_TICKS, 32'd0);
        cfg_row(REG_C3_EXIT_TICKS, 32'd0);
        cfg_row(REG_C3_ENTER_TICKS, 32'd0);
        pass_row(1'b0, 1'b0, 32'hFF00_0000, 32'h0000_0000);
        pass_row(1'b0, 1'b0, 32'd7, 32'd8);
        pass_row(1'b0, 1'b0, 32'd7, 32'd8);
        pass_row(1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part
        i = 0;
        while (i < directed_rows.size()) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                drain_results();
                while (i < directed_rows.size() && directed_rows[i].kind == ROW_CFG) begin
                    write_reg(directed_rows[i].idx, directed_rows[i].val);
                    i++;
                end
                cfg_wr_en <= 1'b0;
            end else begin
                send_pass(directed_rows[i].resched, directed_rows[i].bm, directed_rows[i].t0,
                          directed_rows[i].t1, directed_rows[i].typed, directed_rows[i].want);
                sender_gap();
                i++;
            end
        end

        // Random phases, each with fresh settings
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            write_reg(REG_TIMER_WIDE, $urandom_range(0, 1));
            write_reg(REG_MAX_LEVEL, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 3);
            write_reg(REG_ARBITER_PRESENT, $urandom_range(0, 1));
            if (phase == 1) begin
                write_reg(REG_C2_EXIT_TICKS, '0);
                write_reg(REG_C2_ENTER_TICKS, '0);
                write_reg(REG_C3_EXIT_TICKS, '0);
                write_reg(REG_C3_ENTER_TICKS, '0);
            end else if (phase == 2) begin
                write_reg(REG_C2_EXIT_TICKS, TMR_MASK_32);
                write_reg(REG_C2_ENTER_TICKS, TMR_MASK_32);
                write_reg(REG_C3_EXIT_TICKS, TMR_MASK_32);
                write_reg(REG_C3_ENTER_TICKS, TMR_MASK_32);
            end else begin
                write_reg(REG_C2_EXIT_TICKS, pick_ticks());
                write_reg(REG_C2_ENTER_TICKS, pick_ticks());
                write_reg(REG_C3_EXIT_TICKS, pick_ticks());
                write_reg(REG_C3_ENTER_TICKS, pick_ticks());
            end
            cfg_wr_en <= 1'b0;
            for (int n = 0; n < PHASE_PASSES; n++) begin
                // idling in stretches, none in the final phase
                if (n % 32 == 0)
                    idling_on = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                if (phase == 5 && n == PHASE_PASSES / 2) drain_results();
                random_pass();
                sender_gap();
            end
        end

        // Let the last results arrive, then allow for stray ones
        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
